/* src/bta_pkg.sv */
// Shared types, constants and helper functions of the boundary-tag heap allocator.
`timescale 1ns / 1ps
package bta_pkg;

   localparam int unsigned HEAP_BYTES    = 65536;
   localparam int unsigned GROW_BYTES    = 4096;
   localparam int unsigned INIT_BYTES    = 4096;
   localparam int unsigned HEAP_WORDS    = HEAP_BYTES / 4;
   localparam int unsigned MEM_AW        = $clog2(HEAP_WORDS);
   localparam int unsigned WALK_LIMIT    = HEAP_BYTES / 8 + 2;
   localparam int unsigned WALK_W        = $clog2(WALK_LIMIT + 1);
   localparam int unsigned HEAP_END_W    = $clog2(HEAP_BYTES + 1);
   localparam int unsigned NEED_W        = 17;
   localparam int unsigned FIRST_PAYLOAD = 8;
   localparam int unsigned SPLIT_MIN     = 8;
   localparam int unsigned MIN_BLOCK     = 16;
   localparam int unsigned HEAP_END_RST  = 16 + INIT_BYTES;
   localparam int unsigned INIT_HDR_W    = 3;
   localparam int unsigned INIT_FTR_W    = (8 + INIT_BYTES) / 4;
   localparam int unsigned INIT_EPI_W    = (12 + INIT_BYTES) / 4;
   localparam int unsigned ST_W          = 61;

   typedef logic [31:0] word_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_ZERO     = 2'd2
   } status_type;

   typedef struct packed {
      logic        command;
      logic [15:0] request_size;
      logic [15:0] block_address;
   } req_type;

   typedef struct packed {
      logic [15:0] payload_address;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      AS_P4, AS_P8, AS_B4, AS_BK8, AS_A4, AS_AK8, AS_PK8, AS_PK4
   } asel_type;

   typedef enum logic [1:0] {
      DS_SZ, DS_REST, DS_ONE
   } dsel_type;

   typedef enum logic [4:0] {
      L_NONE, L_ACCEPT, L_FCHK, L_SZK, L_K, L_BEF, L_BS, L_PF, L_AFT, L_NH, L_NF,
      L_SUM, L_CUR, L_PBEF, L_ACHK, L_PASS2, L_FOUND, L_NEXT, L_GROW, L_CARVE,
      L_FIN, L_RES_DONE0, L_RES_FULL, L_RES_ZERO
   } ld_type;

   typedef struct packed {
      logic     rd;
      logic     wr;
      logic     clr;
      asel_type asel;
      dsel_type dsel;
      ld_type   ld;
   } ctl_cmd_type;

   typedef struct packed {
      logic fr_ok;
      logic is_free;
      logic req_zero;
      logic walk_end;
      logic pass2;
      logic size_zero;
      logic fit;
      logic grow_ok;
      logic pu;
      logic nu;
      logic split;
      logic clr_last;
   } dp_status_type;

   function automatic word_type tag_size(input word_type w);
      return {w[31:3], 3'b000};
   endfunction

   function automatic word_type init_word(input logic [MEM_AW-1:0] i);
      word_type v;
      v = '0;
      if (i == MEM_AW'(1) || i == MEM_AW'(2)) begin
         v = word_type'(FIRST_PAYLOAD) | word_type'(1);
      end else if (i == MEM_AW'(INIT_HDR_W) || i == MEM_AW'(INIT_FTR_W)) begin
         v = word_type'(INIT_BYTES);
      end else if (i == MEM_AW'(INIT_EPI_W)) begin
         v = word_type'(1);
      end
      return v;
   endfunction

endpackage

/* src/boundary_tag_heap_allocator.sv */
// Top level of the boundary-tag heap allocator with next-fit search.
//
//   Channel  Ports                          Direction  Content
//   req      req_valid/req_ready/req_data   in         command, request_size, block_address
//   rsp      rsp_valid/rsp_ready/rsp_data   out        payload_address, status
//
// After reset the tag memory is initialized one word per cycle, over all of its words, before
// the first transaction is taken. Each transaction then runs alone through the sequencer,
// with every tag access going through the single memory port. A free whose address lies
// outside the heap is answered without any tag access; an allocate reads the header of
// each block visited by the next-fit walk. The result is held until rsp_ready, and the
// next request is taken after it leaves.
`timescale 1ns / 1ps
module boundary_tag_heap_allocator
   import bta_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   bta_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bta_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* src/bta_datapath.sv */
// Datapath of the heap allocator: tag memory, address arithmetic and working registers.
`timescale 1ns / 1ps
module bta_datapath
   import bta_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   input  req_type       req_data,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   word_type heap_mem [HEAP_WORDS];

   req_type               req_ff, req_in;
   rsp_type               res_ff, res_in;
   word_type              p_ff, p_in, b_ff, b_in, a_ff, a_in, k_ff, k_in, s_ff, s_in;
   word_type              sz_ff, sz_in, bs_ff, bs_in, pfs_ff, pfs_in;
   word_type              nhs_ff, nhs_in, nfs_ff, nfs_in, rest_ff, rest_in;
   word_type              cursor_ff, cursor_in;
   logic                  pu_ff, pu_in, nu_ff, nu_in, split_ff, split_in, pass2_ff, pass2_in;
   logic [NEED_W-1:0]     need_ff, need_in;
   logic [WALK_W-1:0]     n_ff, n_in;
   logic [HEAP_END_W-1:0] heap_end_ff, heap_end_in;
   logic [MEM_AW-1:0]     clr_idx_ff, clr_idx_in;
   word_type              q_ff;
   logic                  oob_ff;

   word_type          rv, rsize, ma, wd, need_ext, ext, words, gsz, have_rest;
   logic              inb;
   logic [NEED_W-1:0] need_sum, need_calc;

   assign rv       = oob_ff ? '0 : q_ff;
   assign rsize    = tag_size(rv);
   assign need_ext = word_type'(need_ff);
   assign ext      = (need_ext > word_type'(GROW_BYTES)) ? need_ext : word_type'(GROW_BYTES);
   assign words    = ext >> 2;
   assign gsz      = (words + {31'b0, words[0]}) << 2;
   assign need_sum = NEED_W'(req_ff.request_size) + NEED_W'(15);
   assign need_calc = (req_ff.request_size <= 16'd8) ? NEED_W'(MIN_BLOCK)
                                                     : {need_sum[NEED_W-1:3], 3'b000};
   assign have_rest = rsize - need_ext;

   always_comb begin
      case (cmd.asel)
         AS_P4:   ma = p_ff - 32'd4;
         AS_P8:   ma = p_ff - 32'd8;
         AS_B4:   ma = b_ff - 32'd4;
         AS_BK8:  ma = b_ff + k_ff - 32'd8;
         AS_A4:   ma = a_ff - 32'd4;
         AS_AK8:  ma = a_ff + k_ff - 32'd8;
         AS_PK8:  ma = p_ff + k_ff - 32'd8;
         AS_PK4:  ma = p_ff + k_ff - 32'd4;
         default: ma = p_ff;
      endcase
      case (cmd.dsel)
         DS_SZ:   wd = sz_ff;
         DS_REST: wd = rest_ff;
         DS_ONE:  wd = 32'd1;
         default: wd = sz_ff;
      endcase
   end

   assign inb = ma < word_type'(HEAP_BYTES);

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         heap_mem[clr_idx_ff] <= init_word(clr_idx_ff);
      end else if (cmd.wr && inb) begin
         heap_mem[ma[MEM_AW+1:2]] <= wd;
      end
      if (cmd.rd) begin
         q_ff   <= heap_mem[ma[MEM_AW+1:2]];
         oob_ff <= !inb;
      end
   end

   assign status.fr_ok     = req_ff.block_address >= 16'd16 &&
                             word_type'(req_ff.block_address) < word_type'(heap_end_ff);
   assign status.is_free   = req_ff.command == CMD_FREE;
   assign status.req_zero  = req_ff.request_size == 16'd0;
   assign status.walk_end  = n_ff == WALK_W'(WALK_LIMIT) || (pass2_ff && b_ff == cursor_ff);
   assign status.pass2     = pass2_ff;
   assign status.size_zero = rsize == '0;
   assign status.fit       = !rv[0] && need_ext <= rsize;
   assign status.grow_ok   = (33'(heap_end_ff) + 33'(gsz)) <= 33'(HEAP_BYTES);
   assign status.pu        = pu_ff;
   assign status.nu        = nu_ff;
   assign status.split     = split_ff;
   assign status.clr_last  = clr_idx_ff == MEM_AW'(HEAP_WORDS - 1);
   assign rsp_data         = res_ff;

   always_comb begin
      req_in      = req_ff;
      res_in      = res_ff;
      p_in        = p_ff;
      b_in        = b_ff;
      a_in        = a_ff;
      k_in        = k_ff;
      s_in        = s_ff;
      sz_in       = sz_ff;
      bs_in       = bs_ff;
      pfs_in      = pfs_ff;
      nhs_in      = nhs_ff;
      nfs_in      = nfs_ff;
      rest_in     = rest_ff;
      cursor_in   = cursor_ff;
      pu_in       = pu_ff;
      nu_in       = nu_ff;
      split_in    = split_ff;
      pass2_in    = pass2_ff;
      need_in     = need_ff;
      n_in        = n_ff;
      heap_end_in = heap_end_ff;
      clr_idx_in  = cmd.clr ? clr_idx_ff + MEM_AW'(1) : clr_idx_ff;
      case (cmd.ld)
         L_ACCEPT: req_in = req_data;
         L_FCHK:   p_in = word_type'(req_ff.block_address);
         L_SZK: begin
            sz_in = rsize;
            k_in  = rsize;
         end
         L_K:      k_in = rsize;
         L_BEF:    b_in = p_ff - rsize;
         L_BS: begin
            bs_in = rsize;
            k_in  = rsize;
         end
         L_PF: begin
            pu_in  = rv[0];
            pfs_in = rsize;
         end
         L_AFT: begin
            a_in = p_ff + rsize;
            s_in = rsize;
         end
         L_NH: begin
            nu_in  = rv[0];
            nhs_in = rsize;
            k_in   = rsize;
         end
         L_NF:     nfs_in = rsize;
         L_SUM: begin
            if (pu_ff) begin
               sz_in = s_ff + nhs_ff;
            end else if (nu_ff) begin
               sz_in = s_ff + pfs_ff;
            end else begin
               sz_in = s_ff + bs_ff + nfs_ff;
            end
         end
         L_CUR:    cursor_in = p_ff;
         L_PBEF: begin
            p_in      = p_ff - rsize;
            cursor_in = p_ff - rsize;
         end
         L_ACHK: begin
            need_in  = need_calc;
            b_in     = cursor_ff;
            n_in     = '0;
            pass2_in = 1'b0;
         end
         L_PASS2: begin
            b_in     = word_type'(FIRST_PAYLOAD);
            n_in     = '0;
            pass2_in = 1'b1;
         end
         L_FOUND: begin
            p_in = b_ff;
            if (!pass2_ff) begin
               cursor_in = b_ff;
            end
         end
         L_NEXT: begin
            b_in = b_ff + rsize;
            n_in = n_ff + WALK_W'(1);
         end
         L_GROW: begin
            p_in        = word_type'(heap_end_ff);
            heap_end_in = heap_end_ff + HEAP_END_W'(gsz);
            sz_in       = gsz;
            k_in        = gsz;
         end
         L_CARVE: begin
            rest_in  = have_rest;
            split_in = have_rest >= word_type'(SPLIT_MIN);
            sz_in    = (have_rest >= word_type'(SPLIT_MIN)) ? (need_ext | 32'd1)
                                                             : (rsize | 32'd1);
         end
         L_FIN: begin
            cursor_in = p_ff;
            res_in    = '{payload_address: p_ff[15:0], status: STATUS_DONE};
         end
         L_RES_DONE0: res_in = '{payload_address: 16'd0, status: STATUS_DONE};
         L_RES_FULL:  res_in = '{payload_address: 16'd0, status: STATUS_NO_SPACE};
         L_RES_ZERO:  res_in = '{payload_address: 16'd0, status: STATUS_ZERO};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= word_type'(FIRST_PAYLOAD);
         heap_end_ff <= HEAP_END_W'(HEAP_END_RST);
         clr_idx_ff  <= '0;
      end else begin
         cursor_ff   <= cursor_in;
         heap_end_ff <= heap_end_in;
         clr_idx_ff  <= clr_idx_in;
      end
      req_ff   <= req_in;
      res_ff   <= res_in;
      p_ff     <= p_in;
      b_ff     <= b_in;
      a_ff     <= a_in;
      k_ff     <= k_in;
      s_ff     <= s_in;
      sz_ff    <= sz_in;
      bs_ff    <= bs_in;
      pfs_ff   <= pfs_in;
      nhs_ff   <= nhs_in;
      nfs_ff   <= nfs_in;
      rest_ff  <= rest_in;
      pu_ff    <= pu_in;
      nu_ff    <= nu_in;
      split_ff <= split_in;
      pass2_ff <= pass2_in;
      need_ff  <= need_in;
      n_ff     <= n_in;
   end

endmodule

/* src/bta_control.sv */
// Control state machine that sequences tag reads, writes and updates of the allocator.
`timescale 1ns / 1ps
module bta_control
   import bta_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [ST_W-1:0] {
      S_CLEAR = ST_W'(1) << 0,  S_IDLE  = ST_W'(1) << 1,  S_DISP  = ST_W'(1) << 2,
      F_RH    = ST_W'(1) << 3,  F_UH    = ST_W'(1) << 4,  F_WH    = ST_W'(1) << 5,
      F_RH2   = ST_W'(1) << 6,  F_UH2   = ST_W'(1) << 7,  F_WF    = ST_W'(1) << 8,
      M_R1    = ST_W'(1) << 9,  M_U1    = ST_W'(1) << 10, M_R2    = ST_W'(1) << 11,
      M_U2    = ST_W'(1) << 12, M_R3    = ST_W'(1) << 13, M_U3    = ST_W'(1) << 14,
      M_R4    = ST_W'(1) << 15, M_U4    = ST_W'(1) << 16, M_R5    = ST_W'(1) << 17,
      M_U5    = ST_W'(1) << 18, M_R6    = ST_W'(1) << 19, M_U6    = ST_W'(1) << 20,
      M_DEC   = ST_W'(1) << 21, MA_WH   = ST_W'(1) << 22, MA_R    = ST_W'(1) << 23,
      MA_U    = ST_W'(1) << 24, MA_WF   = ST_W'(1) << 25, MB_R    = ST_W'(1) << 26,
      MB_U    = ST_W'(1) << 27, MB_WF   = ST_W'(1) << 28, MB_R2   = ST_W'(1) << 29,
      MB_U2   = ST_W'(1) << 30, MB_WH   = ST_W'(1) << 31, MC_WH   = ST_W'(1) << 32,
      MC_R    = ST_W'(1) << 33, MC_U    = ST_W'(1) << 34, MC_R2   = ST_W'(1) << 35,
      MC_U2   = ST_W'(1) << 36, MC_WF   = ST_W'(1) << 37, M_RB    = ST_W'(1) << 38,
      M_UB    = ST_W'(1) << 39, M_RET   = ST_W'(1) << 40, W_RD    = ST_W'(1) << 41,
      W_USE   = ST_W'(1) << 42, G_CHK   = ST_W'(1) << 43, G_WH    = ST_W'(1) << 44,
      G_WF    = ST_W'(1) << 45, G_WE    = ST_W'(1) << 46, C_R     = ST_W'(1) << 47,
      C_U     = ST_W'(1) << 48, C_WH    = ST_W'(1) << 49, C_R2    = ST_W'(1) << 50,
      C_U2    = ST_W'(1) << 51, C_WF    = ST_W'(1) << 52, C_R3    = ST_W'(1) << 53,
      C_U3    = ST_W'(1) << 54, C_WNH   = ST_W'(1) << 55, C_R4    = ST_W'(1) << 56,
      C_U4    = ST_W'(1) << 57, C_WNF   = ST_W'(1) << 58, C_FIN   = ST_W'(1) << 59,
      S_RESP  = ST_W'(1) << 60
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   always_comb begin
      state_in = state_ff;
      cmd      = '{rd: 1'b0, wr: 1'b0, clr: 1'b0, asel: AS_P4, dsel: DS_SZ, ld: L_NONE};
      case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.ld   = L_ACCEPT;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (status.is_free) begin
               if (status.fr_ok) begin
                  cmd.ld   = L_FCHK;
                  state_in = F_RH;
               end else begin
                  cmd.ld   = L_RES_DONE0;
                  state_in = S_RESP;
               end
            end else if (status.req_zero) begin
               cmd.ld   = L_RES_ZERO;
               state_in = S_RESP;
            end else begin
               cmd.ld   = L_ACHK;
               state_in = W_RD;
            end
         end
         F_RH: begin
            cmd.rd   = 1'b1;
            state_in = F_UH;
         end
         F_UH: begin
            cmd.ld   = L_SZK;
            state_in = F_WH;
         end
         F_WH: begin
            cmd.wr   = 1'b1;
            state_in = F_RH2;
         end
         F_RH2: begin
            cmd.rd   = 1'b1;
            state_in = F_UH2;
         end
         F_UH2: begin
            cmd.ld   = L_K;
            state_in = F_WF;
         end
         F_WF: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_PK8;
            state_in = M_R1;
         end
         M_R1: begin
            cmd.rd   = 1'b1;
            cmd.asel = AS_P8;
            state_in = M_U1;
         end
         M_U1: begin
            cmd.ld   = L_BEF;
            state_in = M_R2;
         end
         M_R2: begin
            cmd.rd   = 1'b1;
            cmd.asel = AS_B4;
            state_in = M_U2;
         end
         M_U2: begin
            cmd.ld   = L_BS;
            state_in = M_R3;
         end
         M_R3: begin
            cmd.rd   = 1'b1;
            cmd.asel = AS_BK8;
            state_in = M_U3;
         end
         M_U3: begin
            cmd.ld   = L_PF;
            state_in = M_R4;
         end
         M_R4: begin
            cmd.rd   = 1'b1;
            state_in = M_U4;
         end
         M_U4: begin
            cmd.ld   = L_AFT;
            state_in = M_R5;
         end
         M_R5: begin
            cmd.rd   = 1'b1;
            cmd.asel = AS_A4;
            state_in = M_U5;
         end
         M_U5: begin
            cmd.ld   = L_NH;
            state_in = M_R6;
         end
         M_R6: begin
            cmd.rd   = 1'b1;
            cmd.asel = AS_AK8;
            state_in = M_U6;
         end
         M_U6: begin
            cmd.ld   = L_NF;
            state_in = M_DEC;
         end
         M_DEC: begin
            cmd.ld = L_SUM;
            if (status.pu && status.nu) begin
               state_in = M_RET;
            end else if (status.pu) begin
               state_in = MA_WH;
            end else if (status.nu) begin
               state_in = MB_R;
            end else begin
               state_in = MC_WH;
            end
         end
         MA_WH: begin
            cmd.wr   = 1'b1;
            state_in = MA_R;
         end
         MA_R: begin
            cmd.rd   = 1'b1;
            state_in = MA_U;
         end
         MA_U: begin
            cmd.ld   = L_K;
            state_in = MA_WF;
         end
         MA_WF: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_PK8;
            cmd.ld   = L_CUR;
            state_in = M_RET;
         end
         MB_R: begin
            cmd.rd   = 1'b1;
            state_in = MB_U;
         end
         MB_U: begin
            cmd.ld   = L_K;
            state_in = MB_WF;
         end
         MB_WF: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_PK8;
            state_in = MB_R2;
         end
         MB_R2: begin
            cmd.rd   = 1'b1;
            cmd.asel = AS_P8;
            state_in = MB_U2;
         end
         MB_U2: begin
            cmd.ld   = L_BEF;
            state_in = MB_WH;
         end
         MB_WH: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_B4;
            state_in = M_RB;
         end
         MC_WH: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_B4;
            state_in = MC_R;
         end
         MC_R: begin
            cmd.rd   = 1'b1;
            state_in = MC_U;
         end
         MC_U: begin
            cmd.ld   = L_AFT;
            state_in = MC_R2;
         end
         MC_R2: begin
            cmd.rd   = 1'b1;
            cmd.asel = AS_A4;
            state_in = MC_U2;
         end
         MC_U2: begin
            cmd.ld   = L_K;
            state_in = MC_WF;
         end
         MC_WF: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_AK8;
            state_in = M_RB;
         end
         M_RB: begin
            cmd.rd   = 1'b1;
            cmd.asel = AS_P8;
            state_in = M_UB;
         end
         M_UB: begin
            cmd.ld   = L_PBEF;
            state_in = M_RET;
         end
         M_RET: begin
            if (status.is_free) begin
               cmd.ld   = L_RES_DONE0;
               state_in = S_RESP;
            end else begin
               state_in = C_R;
            end
         end
         W_RD: begin
            if (status.walk_end) begin
               if (status.pass2) begin
                  state_in = G_CHK;
               end else begin
                  cmd.ld   = L_PASS2;
                  state_in = W_RD;
               end
            end else begin
               cmd.rd   = 1'b1;
               cmd.asel = AS_B4;
               state_in = W_USE;
            end
         end
         W_USE: begin
            if (status.size_zero) begin
               if (status.pass2) begin
                  state_in = G_CHK;
               end else begin
                  cmd.ld   = L_PASS2;
                  state_in = W_RD;
               end
            end else if (status.fit) begin
               cmd.ld   = L_FOUND;
               state_in = C_R;
            end else begin
               cmd.ld   = L_NEXT;
               state_in = W_RD;
            end
         end
         G_CHK: begin
            if (status.grow_ok) begin
               cmd.ld   = L_GROW;
               state_in = G_WH;
            end else begin
               cmd.ld   = L_RES_FULL;
               state_in = S_RESP;
            end
         end
         G_WH: begin
            cmd.wr   = 1'b1;
            state_in = G_WF;
         end
         G_WF: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_PK8;
            state_in = G_WE;
         end
         G_WE: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_PK4;
            cmd.dsel = DS_ONE;
            state_in = M_R1;
         end
         C_R: begin
            cmd.rd   = 1'b1;
            state_in = C_U;
         end
         C_U: begin
            cmd.ld   = L_CARVE;
            state_in = C_WH;
         end
         C_WH: begin
            cmd.wr   = 1'b1;
            state_in = C_R2;
         end
         C_R2: begin
            cmd.rd   = 1'b1;
            state_in = C_U2;
         end
         C_U2: begin
            cmd.ld   = L_K;
            state_in = C_WF;
         end
         C_WF: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_PK8;
            state_in = status.split ? C_R3 : C_FIN;
         end
         C_R3: begin
            cmd.rd   = 1'b1;
            state_in = C_U3;
         end
         C_U3: begin
            cmd.ld   = L_AFT;
            state_in = C_WNH;
         end
         C_WNH: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_A4;
            cmd.dsel = DS_REST;
            state_in = C_R4;
         end
         C_R4: begin
            cmd.rd   = 1'b1;
            cmd.asel = AS_A4;
            state_in = C_U4;
         end
         C_U4: begin
            cmd.ld   = L_K;
            state_in = C_WNF;
         end
         C_WNF: begin
            cmd.wr   = 1'b1;
            cmd.asel = AS_AK8;
            cmd.dsel = DS_REST;
            state_in = C_FIN;
         end
         C_FIN: begin
            cmd.ld   = L_FIN;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
